>>> design/eroc_pkg.sv
`default_nettype none
package eroc_pkg;

  // Field widths
  localparam int LAT_W = 24;
  localparam int AXIS_W = 33;
  localparam int ECC_W = 32;
  localparam int RADIUS_W = 34;
  localparam int CFG_W = 33;

  // Register reset values (WGS84)
  localparam logic [AXIS_W-1:0] AXIS_RESET = 33'd6531212288;
  localparam logic [ECC_W-1:0] ECC_RESET = 32'd28752143;
  localparam logic [ECC_W-1:0] ECC_MAX = 32'h8000_0000;

  // Register indexes
  typedef enum logic [0:0] {
    CFG_SEMI_MAJOR = 1'b0,
    CFG_ECC        = 1'b1
  } cfg_idx_t;

  // Degrees (Q16) to Q30 radians: pi_q30 / (180 * 2^16) = 285 + FRAC_C / (180 * 2^16)
  localparam logic [22:0] LAT_MAX = 23'd5898240;
  localparam logic [8:0] INT_C = 9'd285;
  localparam logic [23:0] FRAC_C = 24'd11262626;
  localparam logic [7:0] DEG_DIV = 8'd180;
  // floor(2^38 / 180)
  localparam logic [30:0] RK180 = 31'd1527099483;

  // Series terms past the sixth truncate to zero for any angle up to pi/2
  localparam int SINE_TERMS = 6;
  localparam int SINE_RSH = 34;

  // Digit-recurrence units, two steps per stage; the last divider stage takes one
  localparam int SQ_STEPS = 32;
  localparam int SQ_STAGES = SQ_STEPS / 2;
  localparam int DIV_STEPS = 33;
  localparam int DIV_STAGES = (DIV_STEPS + 1) / 2;

  localparam int FRONT_STAGES = 5;
  localparam int NSTAGES = FRONT_STAGES + 3 * SINE_TERMS + 3 + SQ_STAGES + DIV_STAGES + 4;

  typedef struct packed {
    logic [62:0] v;
    logic [62:0] res;
  } sq_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [32:0] q;
  } dv_t;

  // One step of the bitwise integer square root
  function automatic sq_t sqrt_step(input logic [62:0] v, input logic [62:0] res,
                                    input logic [62:0] bitv);
    logic [63:0] t;
    sq_t o;
    t = {1'b0, res} + {1'b0, bitv};
    if ({1'b0, v} >= t) begin
      o.v = v - t[62:0];
      o.res = (res >> 1) + bitv;
    end else begin
      o.v = v;
      o.res = res >> 1;
    end
    return o;
  endfunction

  // One step of restoring division with a zero dividend tail
  function automatic dv_t div_step(input logic [31:0] rem, input logic [32:0] q,
                                   input logic [32:0] d);
    logic [32:0] r2;
    dv_t o;
    r2 = {rem, 1'b0};
    if (r2 >= d) begin
      o.rem = 32'(r2 - d);
      o.q = {q[31:0], 1'b1};
    end else begin
      o.rem = r2[31:0];
      o.q = {q[31:0], 1'b0};
    end
    return o;
  endfunction

endpackage
`default_nettype wire

>>> design/eroc_if.sv
`default_nettype none
// Latitude channel
interface eroc_in_if;
  logic valid;
  logic ready;
  logic signed [23:0] latitude;
  modport source (output valid, output latitude, input ready);
  modport sink (input valid, input latitude, output ready);
endinterface

// Radii channel
interface eroc_out_if;
  logic valid;
  logic ready;
  logic [33:0] meridional_radius;
  logic [33:0] transverse_radius;
  logic [33:0] conformal_radius;
  modport source (output valid, output meridional_radius, output transverse_radius,
                  output conformal_radius, input ready);
  modport sink (input valid, input meridional_radius, input transverse_radius,
                input conformal_radius, output ready);
endinterface
`default_nettype wire

>>> design/ellipsoid_radii_of_curvature_unit.sv
`default_nettype none
// Ellipsoid radii of curvature: one latitude beat in, one beat of M, N, R out.
// Latency: 63 register stages from the input beat to the result register.
// Throughput one beat per cycle; the whole pipeline holds while the output register is full
// and not taken. Most of the stages sit in the sine series, square-root and divider chains.
// Reset (synchronous, rst_n low) clears the valid bits and loads WGS84 into the registers.
module ellipsoid_radii_of_curvature_unit (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  eroc_in_if.sink                      in_chan,
  eroc_out_if.source                   out_chan,
  input  wire logic                    cfg_wr_en,
  input  wire eroc_pkg::cfg_idx_t      cfg_index,
  input  wire logic [eroc_pkg::CFG_W-1:0] cfg_data
);
  import eroc_pkg::*;

  localparam int ST_SINE = FRONT_STAGES;
  localparam int ST_SQ = ST_SINE + 3 * SINE_TERMS + 3;
  localparam int ST_DIV = ST_SQ + SQ_STAGES;

  logic [AXIS_W-1:0] axis_r;
  logic [ECC_W-1:0] ecc_r;
  logic [ECC_W-1:0] e2;
  logic [32:0] qv;
  logic vld_r [NSTAGES];
  logic en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= AXIS_RESET;
      ecc_r <= ECC_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SEMI_MAJOR: axis_r <= cfg_data;
        CFG_ECC:        ecc_r <= cfg_data[ECC_W-1:0];
        default: ;
      endcase
    end
  end

  assign e2 = (ecc_r > ECC_MAX) ? ECC_MAX : ecc_r;
  assign qv = 33'h1_0000_0000 - {1'b0, e2};

  // Global advance: pipeline moves whenever the output register can take a beat
  assign en = !vld_r[NSTAGES-1] || out_chan.ready;
  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSTAGES; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_chan.valid;
      for (int i = 1; i < NSTAGES; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // ---------------------------------------------------------------- front end
  logic [23:0] raw;
  logic [23:0] mag24;
  logic [22:0] mag_nxt;
  logic [22:0] mag_r;
  logic [45:0] p_r;
  logic [30:0] base1_r, base2_r;
  logic [46:0] p_full;
  logic [31:0] base_full;
  logic [29:0] z_r;
  logic [60:0] zk_r;
  logic [30:0] rad_r;
  logic [30:0] rad_nxt;
  logic [22:0] rq0;
  logic [30:0] rqd;
  logic [29:0] rrem;
  logic [61:0] radsq;

  // magnitude with saturation at the poles
  assign raw = in_chan.latitude;
  assign mag24 = raw[23] ? (~raw + 24'd1) : raw;
  assign mag_nxt = (mag24 > {1'b0, LAT_MAX}) ? LAT_MAX : mag24[22:0];

  assign p_full = mag_r * FRAC_C;
  assign base_full = mag_r * INT_C;

  // divide by 180 via reciprocal, one correction step
  assign rq0 = zk_r[60:38];
  assign rqd = rq0 * DEG_DIV;
  assign rrem = z_r - rqd[29:0];
  assign rad_nxt = base2_r + {8'd0, rq0} + {30'd0, (rrem >= {22'd0, DEG_DIV})};
  assign radsq = rad_r * rad_r;

  logic [30:0] trm_r [SINE_TERMS+1];
  logic [31:0] r2_r [SINE_TERMS+1];
  logic signed [32:0] sum_r [SINE_TERMS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
      p_r <= p_full[45:0];
      base1_r <= base_full[30:0];
      z_r <= p_r[45:16];
      zk_r <= p_r[45:16] * RK180;
      base2_r <= base1_r;
      rad_r <= rad_nxt;
      trm_r[0] <= rad_r;
      r2_r[0] <= radsq[61:30];
      sum_r[0] <= $signed({2'b00, rad_r});
    end
  end

  // ---------------------------------------------------------------- sine series
  for (genvar k = 1; k <= SINE_TERMS; k++) begin : g_term
    localparam logic [63:0] DEN64 = 64'(2 * k * (2 * k + 1));
    localparam logic [9:0] DEN = DEN64[9:0];
    localparam logic [63:0] RK64 = (64'd1 << SINE_RSH) / DEN64;
    localparam logic [31:0] RK = RK64[31:0];

    logic [61:0] tprod;
    logic [32:0] wa_r, wb_r;
    logic [64:0] wk_r;
    logic [31:0] ra_r, rb_r;
    logic signed [32:0] sa_r, sb_r;
    logic [30:0] q0;
    logic [40:0] qd;
    logic [32:0] rem;
    logic [30:0] term;
    logic signed [32:0] sum_nxt;

    assign tprod = trm_r[k-1] * r2_r[k-1];
    assign q0 = wk_r[64:SINE_RSH];
    assign qd = q0 * DEN;
    assign rem = wb_r - qd[32:0];
    assign term = q0 + {30'd0, (rem >= {23'd0, DEN})};
    assign sum_nxt = (k % 2 == 1) ? (sb_r - $signed({2'b00, term}))
                                  : (sb_r + $signed({2'b00, term}));

    // multiply, reciprocal, correct and accumulate
    always_ff @(posedge clk) begin
      if (en) begin
        wa_r <= {1'b0, tprod[61:30]};
        ra_r <= r2_r[k-1];
        sa_r <= sum_r[k-1];
        wk_r <= wa_r * RK;
        wb_r <= wa_r;
        rb_r <= ra_r;
        sb_r <= sa_r;
        trm_r[k] <= term;
        r2_r[k] <= rb_r;
        sum_r[k] <= sum_nxt;
      end
    end
  end

  // ---------------------------------------------------------------- x = 1 - e2 s^2
  logic signed [32:0] sum_fin;
  logic [30:0] s_nxt, s_r, s2_r;
  logic [61:0] ssq;
  logic [62:0] es;
  logic [32:0] x_r;

  assign sum_fin = sum_r[SINE_TERMS];
  assign s_nxt = (sum_fin < 0) ? 31'd0 :
                 (sum_fin > 33'sd1073741824) ? 31'd1073741824 : sum_fin[30:0];
  assign ssq = s_r * s_r;
  assign es = e2 * s2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
      s2_r <= ssq[60:30];
      x_r <= 33'h1_0000_0000 - es[62:30];
    end
  end

  // ---------------------------------------------------------------- square roots
  sq_t sq_r [SQ_STAGES];
  logic [32:0] sx_r [SQ_STAGES];
  sq_t cq_r [SQ_STAGES];

  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sq
    localparam logic [62:0] B0 = 63'd1 << (2 * (SQ_STEPS - 1 - 2 * j));
    localparam logic [62:0] B1 = 63'd1 << (2 * (SQ_STEPS - 2 - 2 * j));
    sq_t in_x, mid_x, in_q, mid_q;
    logic [32:0] xin;

    if (j == 0) begin : g_first
      assign in_x = '{v: {x_r[32:0], 30'd0}, res: 63'd0};
      assign in_q = '{v: {qv, 30'd0}, res: 63'd0};
      assign xin = x_r;
    end else begin : g_rest
      assign in_x = sq_r[j-1];
      assign in_q = cq_r[j-1];
      assign xin = sx_r[j-1];
    end

    assign mid_x = sqrt_step(in_x.v, in_x.res, B0);
    assign mid_q = sqrt_step(in_q.v, in_q.res, B0);

    // item lane
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[j] <= sqrt_step(mid_x.v, mid_x.res, B1);
        sx_r[j] <= xin;
      end
    end

    // free-running lane for sqrt(1 - e2), settles after a register write
    always_ff @(posedge clk) begin
      cq_r[j] <= sqrt_step(mid_q.v, mid_q.res, B1);
    end
  end

  logic [31:0] rq;
  assign rq = cq_r[SQ_STAGES-1].res[31:0];

  // ---------------------------------------------------------------- reciprocals
  dv_t dix_r [DIV_STAGES];
  dv_t dis_r [DIV_STAGES];
  logic [32:0] dx_r [DIV_STAGES];
  logic [31:0] drx_r [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    dv_t in_ix, in_is, mid_ix, mid_is, out_ix, out_is;
    logic [32:0] dxin;
    logic [31:0] drxin;

    if (j == 0) begin : g_first
      // 2^63 / x and 2^62 / rx with 33 quotient bits
      assign in_ix = '{rem: 32'h4000_0000, q: 33'd0};
      assign in_is = '{rem: 32'h2000_0000, q: 33'd0};
      assign dxin = sx_r[SQ_STAGES-1];
      assign drxin = sq_r[SQ_STAGES-1].res[31:0];
    end else begin : g_rest
      assign in_ix = dix_r[j-1];
      assign in_is = dis_r[j-1];
      assign dxin = dx_r[j-1];
      assign drxin = drx_r[j-1];
    end

    assign mid_ix = div_step(in_ix.rem, in_ix.q, dxin);
    assign mid_is = div_step(in_is.rem, in_is.q, {1'b0, drxin});

    if (2 * j + 1 < DIV_STEPS) begin : g_two
      assign out_ix = div_step(mid_ix.rem, mid_ix.q, dxin);
      assign out_is = div_step(mid_is.rem, mid_is.q, {1'b0, drxin});
    end else begin : g_one
      assign out_ix = mid_ix;
      assign out_is = mid_is;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dix_r[j] <= out_ix;
        dis_r[j] <= out_is;
        dx_r[j] <= dxin;
        drx_r[j] <= drxin;
      end
    end
  end

  // ---------------------------------------------------------------- radii products
  logic [32:0] ix;
  logic [31:0] isq;
  logic [64:0] np_r, t1_r;
  logic [65:0] aq_r;
  logic [32:0] ix1_r;
  logic [31:0] is1_r, is2_r;
  logic [33:0] n2_r, n3_r, r3_r;
  logic [66:0] rp_r, mp1_r;
  logic [67:0] mp2_r;
  logic [33:0] m_out_r, n_out_r, r_out_r;

  assign ix = dix_r[DIV_STAGES-1].q;
  assign isq = dis_r[DIV_STAGES-1].q[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      np_r <= axis_r * isq;
      t1_r <= axis_r * rq;
      aq_r <= axis_r * qv;
      ix1_r <= ix;
      is1_r <= isq;

      n2_r <= np_r[64:31];
      rp_r <= t1_r[64:31] * ix1_r;
      mp1_r <= aq_r[65:32] * ix1_r;
      is2_r <= is1_r;

      n3_r <= n2_r;
      r3_r <= rp_r[64:31];
      mp2_r <= mp1_r[66:31] * is2_r;

      m_out_r <= mp2_r[64:31];
      n_out_r <= n3_r;
      r_out_r <= r3_r;
    end
  end

  assign out_chan.valid = vld_r[NSTAGES-1];
  assign out_chan.meridional_radius = m_out_r;
  assign out_chan.transverse_radius = n_out_r;
  assign out_chan.conformal_radius = r_out_r;

endmodule
`default_nettype wire

>>> sim/eroc_radii_checker.sv
module eroc_radii_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  eroc_in_if.sink   lat_mon,
  eroc_out_if.sink  rad_mon,
  input  wire logic cfg_wr_en,
  input  wire eroc_pkg::cfg_idx_t cfg_index,
  input  wire logic [eroc_pkg::CFG_W-1:0] cfg_data,
  output int        fail_count,
  output int        pending,
  output int        radii_seen
);
  import eroc_pkg::*;

  typedef struct {
    logic [33:0] m;
    logic [33:0] n;
    logic [33:0] r;
  } radii_t;

  localparam int SERIES_TERMS = 32;

  logic [32:0] axis_q;
  logic [31:0] ecc_q;
  radii_t radii_q[$];

  // exact-width square root, bitwise
  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] mulsh(input logic [63:0] u, input logic [63:0] v,
                                        input int sh);
    logic [127:0] p;
    p = {64'd0, u} * {64'd0, v};
    return 64'(p >> sh);
  endfunction

  function automatic radii_t radii_at(input logic [23:0] lat, input logic [32:0] a_in,
                                      input logic [31:0] e_in);
    logic [63:0] mag, rad, rad2, term, s, s2, x, q, rx, rq, ix, is_, a, e2;
    longint sum;
    radii_t o;
    mag = lat[23] ? (64'h1000000 - lat) : {40'd0, lat};
    if (mag > 64'd5898240) mag = 64'd5898240;
    a = {31'd0, a_in};
    e2 = (e_in > 32'h8000_0000) ? 64'h8000_0000 : {32'd0, e_in};
    rad = (mag * 64'd3373259426) / (64'd180 * 64'd65536);
    rad2 = (rad * rad) >> 30;
    term = rad;
    sum = longint'(rad);
    for (int k = 1; k < SERIES_TERMS; k++) begin
      term = ((term * rad2) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
    s = 64'(sum);
    s2 = (s * s) >> 30;
    x = (64'd1 << 32) - ((e2 * s2) >> 30);
    q = (64'd1 << 32) - e2;
    rx = root64(x << 30);
    rq = root64(q << 30);
    ix = (64'd1 << 63) / x;
    is_ = (64'd1 << 62) / rx;
    o.n = 34'(mulsh(a, is_, 31));
    o.r = 34'(mulsh(mulsh(a, rq, 31), ix, 31));
    o.m = 34'(mulsh(mulsh(mulsh(a, q, 32), ix, 31), is_, 31));
    return o;
  endfunction

  assign pending = radii_q.size();

  always @(posedge clk) begin
    radii_t exp_r;
    if (!rst_n) begin
      axis_q <= AXIS_RESET;
      ecc_q <= ECC_RESET;
      fail_count <= 0;
      radii_seen <= 0;
      radii_q.delete();
    end else begin
      // register shadow
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SEMI_MAJOR: axis_q <= cfg_data[32:0];
          CFG_ECC:        ecc_q <= cfg_data[31:0];
          default: ;
        endcase
      end
      // predict on accepted latitude beat
      if (lat_mon.valid && lat_mon.ready)
        radii_q.push_back(radii_at(lat_mon.latitude, axis_q, ecc_q));
      // compare on accepted result beat
      if (rad_mon.valid && rad_mon.ready) begin
        radii_seen <= radii_seen + 1;
        if (radii_q.size() == 0) begin
          $display("%0t: unexpected result beat M=%0d N=%0d R=%0d", $time,
                   rad_mon.meridional_radius, rad_mon.transverse_radius,
                   rad_mon.conformal_radius);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = radii_q.pop_front();
          if (exp_r.m !== rad_mon.meridional_radius || exp_r.n !== rad_mon.transverse_radius ||
              exp_r.r !== rad_mon.conformal_radius) begin
            $display("%0t: radii mismatch expected M=%0d N=%0d R=%0d actual M=%0d N=%0d R=%0d",
                     $time, exp_r.m, exp_r.n, exp_r.r, rad_mon.meridional_radius,
                     rad_mon.transverse_radius, rad_mon.conformal_radius);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

>>> sim/tb_ellipsoid_radii_of_curvature_unit.sv
module tb_ellipsoid_radii_of_curvature_unit;
  import eroc_pkg::*;

  localparam int PIPE_WAIT = 80;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  cfg_idx_t cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int fail_count, pending, radii_seen;
  int hold_reqs;

  eroc_in_if in_chan();
  eroc_out_if out_chan();

  ellipsoid_radii_of_curvature_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  eroc_radii_checker u_checker (
    .clk(clk), .rst_n(rst_n), .lat_mon(in_chan.sink), .rad_mon(out_chan.sink),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .radii_seen(radii_seen)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // result side back-pressure
  initial begin
    int g;
    int holds_done;
    holds_done = 0;
    out_chan.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_reqs != holds_done) begin
        out_chan.ready <= 1'b0;
        repeat (200) @(posedge clk);
        holds_done++;
      end else if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        out_chan.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_lat(input logic [23:0] lat, input bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_chan.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.latitude <= lat;
    @(posedge clk iff in_chan.ready);
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (PIPE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [23:0] rand_lat();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 24'($urandom);
    if (p == 1) return ($urandom_range(0, 1) ? 24'd5898240 : -24'sd5898240);
    return 24'($signed($urandom_range(0, 11796480)) - 5898240);
  endfunction

  task automatic random_run(input int n);
    for (int i = 0; i < n; i++) send_lat(rand_lat(), 1'b0);
  endtask

  logic [23:0] corner_lats[13] = '{24'd0, 24'd1, 24'hFFFFFF, 24'd5898240, -24'sd5898240,
    24'd5898241, 24'h7FFFFF, 24'h800000, 24'd2949120, -24'sd2949120, 24'd65536,
    24'd5898239, 24'h800001};

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_SEMI_MAJOR;
    cfg_data = '0;
    in_chan.valid = 1'b0;
    in_chan.latitude = '0;
    hold_reqs = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner latitudes on reset registers
    foreach (corner_lats[i]) send_lat(corner_lats[i], 1'b0);
    settle();

    // extremes of both registers
    write_reg(CFG_SEMI_MAJOR, 33'h1_FFFF_FFFF);
    write_reg(CFG_ECC, 33'h0_FFFF_FFFF);
    foreach (corner_lats[i]) send_lat(corner_lats[i], 1'b1);
    settle();
    write_reg(CFG_SEMI_MAJOR, 33'd0);
    write_reg(CFG_ECC, 33'd0);
    for (int i = 0; i < 6; i++) send_lat(corner_lats[i], 1'b0);
    settle();
    write_reg(CFG_SEMI_MAJOR, 33'd1);
    write_reg(CFG_ECC, 33'h0_8000_0000);
    random_run(100);
    settle();

    // long receiver hold with the sender streaming
    write_reg(CFG_SEMI_MAJOR, 33'd6531212288);
    write_reg(CFG_ECC, 33'd28752143);
    hold_reqs <= hold_reqs + 1;
    for (int i = 0; i < 150; i++) send_lat(rand_lat(), 1'b1);
    random_run(350);
    settle();

    // several random ellipsoids
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_SEMI_MAJOR, {1'($urandom), 32'($urandom)});
      write_reg(CFG_ECC, {1'b0, 32'($urandom)});
      random_run(180);
      settle();
    end

    $display("Covered %0d result beats: corner latitudes, register extremes,", radii_seen);
    $display("saturating eccentricity, random ellipsoids and long output stalls.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

>>> ellipsoid_radii_of_curvature_unit.f
design/eroc_pkg.sv
design/eroc_if.sv
design/ellipsoid_radii_of_curvature_unit.sv
sim/eroc_radii_checker.sv
sim/tb_ellipsoid_radii_of_curvature_unit.sv
